### design/rrs_pkg.sv
// Shared types and constants for the round-robin schedule simulator.
// Holds the input and result word structs, the slice status struct and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

    localparam int DEF_MAX_PROCS = 16;

    localparam int ARR_W      = 16;
    localparam int BURST_W    = 16;
    localparam int QUANTUM_W  = 16;
    localparam int OUT_TIME_W = 21;
    localparam int OUT_IDX_W  = 4;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RST = QUANTUM_W'(4);

    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic               last_process;
    } t_in_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]  process_index;
        logic [OUT_TIME_W-1:0] completion_time;
        logic [OUT_TIME_W-1:0] turnaround_time;
        logic [OUT_TIME_W-1:0] waiting_time;
        logic                  last_result;
    } t_out_item;

    // Outcome of one visit of a process during a sweep.
    typedef struct packed {
        logic eligible;
        logic finish;
        logic pending;
    } t_slice_flags;

endpackage

`default_nettype wire

### design/rrs_slice.sv
// Shared slice unit: runs one process for at most one quantum from the current time.
// Depends on rrs_pkg for widths and the slice status struct.
`timescale 1ns / 1ps
`default_nettype none

module rrs_slice #(
    parameter int TIME_W = 21
) (
    input  wire logic [TIME_W-1:0]            i_time,
    input  wire logic [rrs_pkg::ARR_W-1:0]     i_arrival,
    input  wire logic [rrs_pkg::BURST_W-1:0]   i_remaining,
    input  wire logic [rrs_pkg::QUANTUM_W-1:0] i_quantum,
    output rrs_pkg::t_slice_flags              o_flags,
    output logic [TIME_W-1:0]                  o_time,
    output logic [rrs_pkg::BURST_W-1:0]        o_remaining
);
    import rrs_pkg::*;

    logic                 w_live;
    logic                 w_over;
    logic [BURST_W-1:0]   w_step;

    always_comb begin
        w_live = (i_remaining != '0);
        w_over = (i_remaining > BURST_W'(i_quantum));
        w_step = w_over ? BURST_W'(i_quantum) : i_remaining;

        o_flags.eligible = w_live && (TIME_W'(i_arrival) <= i_time);
        o_flags.pending  = w_live && !o_flags.eligible;
        o_flags.finish   = o_flags.eligible && !w_over;

        o_time      = i_time + TIME_W'(w_step);
        o_remaining = w_over ? (i_remaining - BURST_W'(i_quantum)) : '0;
    end

endmodule

`default_nettype wire

### design/round_robin_schedule_simulator.sv
// Top level of the round-robin schedule simulator: loader, sweep sequencer and result stage.
// Depends on rrs_pkg and on rrs_slice, the shared slice unit.
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_ready    t_in_item, one process per word
//   out      output     o_out_valid / i_out_ready  t_out_item, one per loaded process
//   cfg      input      i_cfg_valid / o_cfg_ready  time quantum, always taken
//
// Load words are taken one per cycle. After the closing word the sequencer sweeps the
// stores through the single slice unit and the registered store reads, visiting each
// process in S_RD and S_EX and closing each sweep in S_CHK; the run depends on the data.
// Each result then passes S_ORD, S_OTAT, S_OFMT and S_OSEND, which holds on an output stall.
// Reset is synchronous and active low; it clears the counts, the time and the quantum
// to four. The input side is not ready from the closing word until the last result goes.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_schedule_simulator #(
    parameter int MAX_PROCS = rrs_pkg::DEF_MAX_PROCS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire rrs_pkg::t_in_item            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output rrs_pkg::t_out_item                o_out_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [rrs_pkg::QUANTUM_W-1:0] i_cfg_data
);
    import rrs_pkg::*;

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int TIME_W = BURST_W + CNT_W;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_CHK   = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_EX    = 8'b0000_1000,
        S_ORD   = 8'b0001_0000,
        S_OTAT  = 8'b0010_0000,
        S_OFMT  = 8'b0100_0000,
        S_OSEND = 8'b1000_0000
    } t_state;

    // Process stores; only entries loaded in the current set are visited.
    logic [ARR_W-1:0]   arrival_mem    [MAX_PROCS];
    logic [BURST_W-1:0] burst_mem      [MAX_PROCS];
    logic [BURST_W-1:0] remaining_mem  [MAX_PROCS];
    logic [TIME_W-1:0]  completion_mem [MAX_PROCS];

    t_state               r_state, n_state;
    logic [QUANTUM_W-1:0] r_quantum;
    logic [CNT_W-1:0]     r_loaded, n_loaded;
    logic [CNT_W-1:0]     r_finished, n_finished;
    logic [TIME_W-1:0]    r_time, n_time;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_idle, n_idle;
    logic                 r_min_vld, n_min_vld;
    logic [ARR_W-1:0]     r_min, n_min;
    logic                 r_out_vld, n_out_vld;
    t_out_item            r_out, n_out;
    logic [TIME_W-1:0]    r_tat, n_tat;
    logic [TIME_W-1:0]    r_ct, n_ct;
    logic [BURST_W-1:0]   r_bt, n_bt;

    logic [ARR_W-1:0]     r_rd_arr;
    logic [BURST_W-1:0]   r_rd_burst;
    logic [BURST_W-1:0]   r_rd_rem;
    logic [TIME_W-1:0]    r_rd_comp;

    logic                 w_in_acc;
    logic                 w_room;
    logic [IDX_W-1:0]     w_load_idx;
    logic [CNT_W-1:0]     w_last_cnt;
    logic [IDX_W-1:0]     w_last_idx;
    logic [QUANTUM_W-1:0] w_quantum;

    t_slice_flags         w_flags;
    logic [TIME_W-1:0]    w_slice_time;
    logic [BURST_W-1:0]   w_slice_rem;

    logic                 w_rem_we;
    logic [IDX_W-1:0]     w_rem_addr;
    logic [BURST_W-1:0]   w_rem_wdata;
    logic                 w_comp_we;
    logic [TIME_W-1:0]    w_comp_wdata;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_room     = (r_loaded < CNT_W'(MAX_PROCS));
    assign w_load_idx = r_loaded[IDX_W-1:0];
    assign w_last_cnt = r_loaded - CNT_W'(1);
    assign w_last_idx = w_last_cnt[IDX_W-1:0];
    assign w_quantum  = (r_quantum == '0) ? QUANTUM_W'(1) : r_quantum;

    rrs_slice #(
        .TIME_W (TIME_W)
    ) u_slice (
        .i_time      (r_time),
        .i_arrival   (r_rd_arr),
        .i_remaining (r_rd_rem),
        .i_quantum   (w_quantum),
        .o_flags     (w_flags),
        .o_time      (w_slice_time),
        .o_remaining (w_slice_rem)
    );

    // Store write ports: loads write at the fill position, sweeps at the visited entry.
    always_comb begin
        w_rem_we     = 1'b0;
        w_rem_addr   = r_idx;
        w_rem_wdata  = w_slice_rem;
        w_comp_we    = 1'b0;
        w_comp_wdata = w_slice_time;
        if (r_state == S_LOAD) begin
            w_rem_addr   = w_load_idx;
            w_rem_wdata  = i_in_data.burst_time;
            w_rem_we     = w_in_acc && w_room;
            w_comp_wdata = TIME_W'(i_in_data.arrival_time);
            w_comp_we    = w_in_acc && w_room && (i_in_data.burst_time == '0);
        end else if (r_state == S_EX) begin
            w_rem_we  = w_flags.eligible;
            w_comp_we = w_flags.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            arrival_mem[w_load_idx] <= i_in_data.arrival_time;
            burst_mem[w_load_idx]   <= i_in_data.burst_time;
        end
        if (w_rem_we) begin
            remaining_mem[w_rem_addr] <= w_rem_wdata;
        end
        if (w_comp_we) begin
            completion_mem[w_rem_addr] <= w_comp_wdata;
        end
        r_rd_arr   <= arrival_mem[r_idx];
        r_rd_burst <= burst_mem[r_idx];
        r_rd_rem   <= remaining_mem[r_idx];
        r_rd_comp  <= completion_mem[r_idx];
    end

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_finished = r_finished;
        n_time     = r_time;
        n_idx      = r_idx;
        n_idle     = r_idle;
        n_min_vld  = r_min_vld;
        n_min      = r_min;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_tat      = r_tat;
        n_ct       = r_ct;
        n_bt       = r_bt;

        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_loaded = r_loaded + CNT_W'(1);
                        if (i_in_data.burst_time == '0) begin
                            n_finished = r_finished + CNT_W'(1);
                        end
                    end
                    if (i_in_data.last_process) begin
                        n_idle    = 1'b1;
                        n_min_vld = 1'b0;
                        n_state   = S_CHK;
                    end
                end
            end
            S_CHK: begin
                // A sweep that ran nothing jumps time to the earliest pending arrival.
                if (r_idle && r_min_vld && (TIME_W'(r_min) > r_time)) begin
                    n_time = TIME_W'(r_min);
                end
                n_idx     = '0;
                n_idle    = 1'b1;
                n_min_vld = 1'b0;
                if (r_finished == r_loaded) begin
                    n_state = S_ORD;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (w_flags.eligible) begin
                    n_idle = 1'b0;
                    n_time = w_slice_time;
                end
                if (w_flags.finish) begin
                    n_finished = r_finished + CNT_W'(1);
                end
                if (w_flags.pending && (!r_min_vld || (r_rd_arr < r_min))) begin
                    n_min_vld = 1'b1;
                    n_min     = r_rd_arr;
                end
                if (r_idx == w_last_idx) begin
                    n_state = S_CHK;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                n_state = S_OTAT;
            end
            S_OTAT: begin
                n_ct    = r_rd_comp;
                n_tat   = r_rd_comp - TIME_W'(r_rd_arr);
                n_bt    = r_rd_burst;
                n_state = S_OFMT;
            end
            S_OFMT: begin
                n_out.process_index   = OUT_IDX_W'(r_idx);
                n_out.completion_time = OUT_TIME_W'(r_ct);
                n_out.turnaround_time = OUT_TIME_W'(r_tat);
                n_out.waiting_time    = OUT_TIME_W'(r_tat - TIME_W'(r_bt));
                n_out.last_result     = (r_idx == w_last_idx);
                n_out_vld             = 1'b1;
                n_state               = S_OSEND;
            end
            S_OSEND: begin
                if (i_out_ready) begin
                    n_out_vld = 1'b0;
                    if (r_idx == w_last_idx) begin
                        n_loaded   = '0;
                        n_finished = '0;
                        n_time     = '0;
                        n_idx      = '0;
                        n_state    = S_LOAD;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_quantum  <= QUANTUM_RST;
            r_loaded   <= '0;
            r_finished <= '0;
            r_time     <= '0;
            r_idx      <= '0;
            r_idle     <= 1'b1;
            r_min_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_finished <= n_finished;
            r_time     <= n_time;
            r_idx      <= n_idx;
            r_idle     <= n_idle;
            r_min_vld  <= n_min_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min <= n_min;
        r_out <= n_out;
        r_tat <= n_tat;
        r_ct  <= n_ct;
        r_bt  <= n_bt;
    end

endmodule

`default_nettype wire
